>>> hdl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the min-tracking stack: operation codes,
// status codes, stack geometry and the stored entry layout.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // One stack slot: the pushed value and the running minimum at that depth.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] low_val;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

>>> hdl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/min_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// LIFO of signed 32-bit words that reports the running minimum with each
// result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word: mode_i
//   (push, pop, peek; code 3 acts as peek) and value_i. Output channel
//   (out_valid_o / out_stall_i) returns one word per input: top_value_o,
//   min_value_o, is_empty_o and status_o, describing the stack afterward.
//   Entries live in one RAM of STACK_DEPTH slots, each holding the value and
//   the minimum at that depth; the top slot is also cached in registers.
//   Push, peek, a refused pop and a pop that empties the stack go straight
//   to the output register. A pop that leaves a non-empty stack first
//   fetches the new top from the registered RAM read port via ST_POP_WAIT.
//   Throughput: one word per cycle while the output is not stalled; after
//   such a pop the input is held while the core is in ST_POP_WAIT.
//   Push onto a full stack returns status full with the unchanged top; pop
//   of an empty stack returns status empty with zero fields.
//   Reset empties the stack at once; RAM contents are not cleared.
//   While the output word is stalled, in_stall_o holds the input side.
// ----------------------------------------------------------------------------
module min_tracking_stack_core
  import mts_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               mode_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic signed [DATA_W-1:0] min_value_o,
  output logic                     is_empty_o,
  output logic [1:0]               status_o
);

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  entry_t              top_q, top_d;
  logic                out_valid_q, out_valid_d;
  entry_t              out_entry_q, out_entry_d;
  logic                out_empty_q, out_empty_d;
  logic [1:0]          out_status_q, out_status_d;

  logic                accept;
  logic                is_full;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  entry_t              ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              pushed;
  logic [CNT_W-1:0]    cnt_less2;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_full    = (cnt_q == CNT_W'(STACK_DEPTH));
  assign cnt_less2  = cnt_q - CNT_W'(2);

  always_comb begin
    pushed.value   = value_i;
    pushed.low_val = value_i;
    // keep the minimum below unless the new value is smaller
    if ((cnt_q != '0) && !(top_q.low_val > value_i)) begin
      pushed.low_val = top_q.low_val;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    top_d        = top_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_entry_d  = out_entry_q;
    out_empty_d  = out_empty_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = cnt_q[ADDR_W-1:0];
    ram_wdata    = pushed;
    ram_raddr    = cnt_less2[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d  = 1'b1;
          out_status_d = STATUS_OK;
          out_empty_d  = (cnt_q == '0);
          out_entry_d  = (cnt_q == '0) ? entry_t'('0) : top_q;
          case (mode_i)
            MODE_PUSH: begin
              if (is_full) begin
                out_status_d = STATUS_FULL;
              end else begin
                ram_we      = 1'b1;
                top_d       = pushed;
                cnt_d       = cnt_q + CNT_W'(1);
                out_entry_d = pushed;
                out_empty_d = 1'b0;
              end
            end
            MODE_POP: begin
              if (cnt_q == '0) begin
                out_status_d = STATUS_EMPTY;
              end else if (cnt_q == CNT_W'(1)) begin
                cnt_d       = '0;
                out_entry_d = '0;
                out_empty_d = 1'b1;
              end else begin
                // fetch the slot below; the result goes out from ST_POP_WAIT
                cnt_d       = cnt_q - CNT_W'(1);
                ram_re      = 1'b1;
                out_valid_d = 1'b0;
                state_d     = ST_POP_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP_WAIT: begin
        top_d        = entry_t'(ram_rdata);
        out_valid_d  = 1'b1;
        out_entry_d  = entry_t'(ram_rdata);
        out_empty_d  = 1'b0;
        out_status_d = STATUS_OK;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      top_q        <= '0;
      out_valid_q  <= 1'b0;
      out_entry_q  <= '0;
      out_empty_q  <= 1'b1;
      out_status_q <= STATUS_OK;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      top_q        <= top_d;
      out_valid_q  <= out_valid_d;
      out_entry_q  <= out_entry_d;
      out_empty_q  <= out_empty_d;
      out_status_q <= out_status_d;
    end
  end

  mts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_mts_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_entry_q.value;
  assign min_value_o = out_entry_q.low_val;
  assign is_empty_o  = out_empty_q;
  assign status_o    = out_status_q;

endmodule

>>> hdl/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks on the min-tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker
  import mts_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [1:0]               mode_i,
  input logic signed [DATA_W-1:0] value_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] top_value_o,
  input logic signed [DATA_W-1:0] min_value_o,
  input logic                     is_empty_o,
  input logic [1:0]               status_o
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(top_value_o)
      && $stable(min_value_o) && $stable(status_o))
    else $error("stalled output word changed");

  // the minimum never exceeds the top entry
  a_min_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_empty_o |-> min_value_o <= top_value_o)
    else $error("minimum above top value");

  // an empty stack reports zero fields
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> top_value_o == '0 && min_value_o == '0)
    else $error("empty stack with nonzero fields");

  // refused pop only on an empty stack, refused push only on a non-empty one
  a_status_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK)
      || (status_o == STATUS_EMPTY && is_empty_o)
      || (status_o == STATUS_FULL && !is_empty_o))
    else $error("status inconsistent with empty flag");

  // an accepted push on a free output shows its value next cycle, unless full
  a_push_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == MODE_PUSH && !(out_valid_o && out_stall_i)
      |=> out_valid_o && (status_o == STATUS_FULL || top_value_o == $past(value_i)))
    else $error("push result does not show pushed value");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (.*);

>>> verif/min_tracking_stack_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core_tb
// Self-checking bench for the min-tracking stack. A short table of directed
// words covers the empty stack, the value extremes, equal minima and the
// unused mode code. Random phases follow: a mixed run, a fill past full, a
// drain past empty and a mixed run under a long output hold-off. A local
// stack model predicts the untyped words; every word is checked in order.
// ----------------------------------------------------------------------------
module min_tracking_stack_core_tb;
  import mts_pkg::*;

  localparam logic [1:0]  MODE_SPARE     = 2'd3;   // unused code, behaves as peek
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          REPORT_MAX     = 10;
  localparam int          DIR_ROWS       = 24;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] low;
    logic                     empty;
    logic [1:0]               status;
  } stack_word_t;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    stack_word_t              want;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               mode_i = MODE_PEEK;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] top_value_o;
  logic signed [DATA_W-1:0] min_value_o;
  logic                     is_empty_o;
  logic [1:0]               status_o;

  min_tracking_stack_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .top_value_o (top_value_o),
    .min_value_o (min_value_o),
    .is_empty_o  (is_empty_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the stack
  logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] low_mem   [STACK_DEPTH];
  int                       depth_q;

  stack_word_t expected_q[$];
  int          mismatches;
  int          snd_idle_pct;
  int          rcv_stall_pct;
  int          hold_left;
  int          quiet_cycles;
  dir_row_t    dir_tab [DIR_ROWS];

  function automatic stack_word_t stack_apply(logic [1:0] mode,
                                              logic signed [DATA_W-1:0] value);
    stack_word_t              res;
    logic signed [DATA_W-1:0] run_low;
    res.status = STATUS_OK;
    if (mode == MODE_PUSH) begin
      if (depth_q >= STACK_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        run_low = value;
        // keep the minimum below unless the new value is strictly smaller
        if (depth_q != 0 && !(low_mem[depth_q-1] > value)) run_low = low_mem[depth_q-1];
        value_mem[depth_q] = value;
        low_mem[depth_q]   = run_low;
        depth_q++;
      end
    end else if (mode == MODE_POP) begin
      if (depth_q == 0) res.status = STATUS_EMPTY;
      else depth_q--;
    end
    if (depth_q == 0) begin
      res.top   = '0;
      res.low   = '0;
      res.empty = 1'b1;
    end else begin
      res.top   = value_mem[depth_q-1];
      res.low   = low_mem[depth_q-1];
      res.empty = 1'b0;
    end
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return $urandom_range(1) ? -32'sd1 : 32'sd0;
      3, 4, 5: return $signed($urandom_range(16)) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return MODE_PUSH;
    if (r < 80) return MODE_POP;
    if (r < 92) return MODE_PEEK;
    return MODE_SPARE;
  endfunction

  // Offer one word and hold it until accepted. Called and returns on a rising edge.
  task automatic drive_word(logic [1:0] mode, logic signed [DATA_W-1:0] value,
                            logic typed = 1'b0, stack_word_t want = '0);
    stack_word_t pred;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    pred = stack_apply(mode, value);
    expected_q.push_back(typed ? want : pred);
  endtask

  task automatic note_mismatch(string what, stack_word_t want, stack_word_t got);
    if (mismatches < REPORT_MAX)
      $display("%0t %s: want top=%0d min=%0d empty=%0b status=%0d,",
               $time, what, want.top, want.low, want.empty, want.status,
               " got top=%0d min=%0d empty=%0b status=%0d",
               got.top, got.low, got.empty, got.status);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk_i) begin
    stack_word_t got;
    stack_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{top: top_value_o, low: min_value_o, empty: is_empty_o, status: status_o};
      if (expected_q.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.top !== want.top || got.low !== want.low ||
            got.empty !== want.empty || got.status !== want.status)
          note_mismatch("mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("min_tracking_stack_core_tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver: random stall, or a counted hold-off when requested
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  initial begin
    depth_q       = 0;
    mismatches    = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_left     = 0;
    quiet_cycles  = 0;

    dir_tab = '{
      '{MODE_POP,   32'sd0,          1'b1, '{32'sd0,   32'sd0,   1'b1, STATUS_EMPTY}},
      '{MODE_PEEK,  32'sd7,          1'b1, '{32'sd0,   32'sd0,   1'b1, STATUS_OK}},
      '{MODE_SPARE, 32'sd9,          1'b1, '{32'sd0,   32'sd0,   1'b1, STATUS_OK}},
      '{MODE_PUSH,  VAL_MAX,         1'b1, '{VAL_MAX,  VAL_MAX,  1'b0, STATUS_OK}},
      '{MODE_PUSH,  VAL_MIN,         1'b1, '{VAL_MIN,  VAL_MIN,  1'b0, STATUS_OK}},
      '{MODE_PUSH,  32'sd0,          1'b1, '{32'sd0,   VAL_MIN,  1'b0, STATUS_OK}},
      '{MODE_PUSH,  -32'sd1,         1'b0, '0},
      '{MODE_PUSH,  VAL_MIN,         1'b1, '{VAL_MIN,  VAL_MIN,  1'b0, STATUS_OK}},
      '{MODE_PEEK,  32'sh5555_5555,  1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b1, '{32'sd0,   32'sd0,   1'b1, STATUS_OK}},
      '{MODE_POP,   32'sh2AAA_AAAA,  1'b1, '{32'sd0,   32'sd0,   1'b1, STATUS_EMPTY}},
      '{MODE_PUSH,  32'sd100,        1'b1, '{32'sd100, 32'sd100, 1'b0, STATUS_OK}},
      '{MODE_PUSH,  32'sd200,        1'b0, '0},
      '{MODE_PUSH,  32'sd50,         1'b0, '0},
      '{MODE_SPARE, 32'shAAAA_AAAA,  1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b0, '0},
      '{MODE_PUSH,  32'shFFFF_FFFF,  1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b0, '0},
      '{MODE_POP,   32'sd0,          1'b1, '{32'sd0,   32'sd0,   1'b1, STATUS_OK}}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) drive_word(dir_tab[i].mode, dir_tab[i].value,
                                    dir_tab[i].typed, dir_tab[i].want);

    // Mixed traffic, no idling
    repeat (60) drive_word(pick_mode(), pick_value());

    // Fill past full with a sparse sender, mostly pushes
    snd_idle_pct = 88;
    while (depth_q < STACK_DEPTH) begin
      if ($urandom_range(9) == 0) drive_word(pick_mode(), pick_value());
      else drive_word(MODE_PUSH, pick_value());
    end
    repeat (6) drive_word(MODE_PUSH, pick_value());

    // Drain past empty with a slow receiver, mostly pops
    snd_idle_pct  = 0;
    rcv_stall_pct = 88;
    while (depth_q > 0) begin
      if ($urandom_range(9) == 0) drive_word(pick_mode(), pick_value());
      else drive_word(MODE_POP, pick_value());
    end
    repeat (4) drive_word(MODE_POP, pick_value());

    // Both sides idle a little; hold the output long enough to back up the input
    snd_idle_pct  = 14;
    rcv_stall_pct = 14;
    hold_left     = HOLD_CYCLES;
    repeat (60) drive_word(pick_mode(), pick_value());

    in_valid_i    <= 1'b0;
    rcv_stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("min_tracking_stack_core_tb OK");
    end else begin
      $display("min_tracking_stack_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mts_pkg.sv
hdl/mts_ram.sv
hdl/min_tracking_stack_core.sv
hdl/mts_checker.sv
verif/min_tracking_stack_core_tb.sv
